// ===== src/aet_pkg.sv =====
// Shared constants for the arc edge trimmer.
`default_nettype none
package aet_pkg;

  // Depth of the pending-sample store; must stay a power of two.
  localparam int MAX_TRIM = 32;
  localparam int SAMPLE_W = 32;
  localparam int TRIM_W   = 6;
  localparam int ARC_W    = 6;
  localparam int PTR_W    = $clog2(MAX_TRIM);
  localparam int CNT_W    = $clog2(MAX_TRIM + 1);

  localparam logic [TRIM_W-1:0] TRIM_RESET = TRIM_W'(10);
  localparam logic [TRIM_W-1:0] TRIM_LIMIT = TRIM_W'(MAX_TRIM);
  localparam logic [ARC_W-1:0]  ARC_SAT    = '1;

  // Bit positions inside the output tuser field.
  localparam int TUSER_TRIMMED = 0;
  localparam int TUSER_DONE    = 1;
  localparam int TUSER_W       = 2;

endpackage : aet_pkg
`default_nettype wire

// ===== src/aet_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
`default_nettype none
module aet_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : aet_ram
`default_nettype wire

// ===== src/arc_edge_trimmer.sv =====
// Arc edge trimmer: sequencer around the pending-sample RAM and the output register.
// A leading-edge result goes to the output register from S_CUR once its item is taken; a
// released sample passes S_POP_RD (RAM read), then S_POP_WR (output), and a gap zero passes
// S_FLUSH1, then S_CUR. A gap releases its pending samples as zeros before its own result; a
// column end drains them in S_FLUSH2. Flushed zeros come one per cycle while the output is
// not stalled; a new item is taken only back in S_IDLE. Reset clears the count,
// pointer, arc position and output register and loads trim_count with 10; RAM is not cleared.
`default_nettype none
module arc_edge_trimmer
  import aet_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration: trim_count.
  input  wire logic                cfg_we_i,
  input  wire logic [TRIM_W-1:0]   cfg_wdata_i,
  // Input item: tdata = sample_in[31:0]; tlast = column_end.
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [SAMPLE_W-1:0] s_axis_tdata,
  input  wire logic                s_axis_tlast,
  // Result item: tdata = sample_out[31:0]; tlast = last_result.
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic      [SAMPLE_W-1:0] m_axis_tdata,
  output logic                     m_axis_tlast,
  // tuser: bit 0 trimmed, bit 1 column_done.
  output logic      [TUSER_W-1:0]  m_axis_tuser
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FLUSH1,
    S_POP_RD,
    S_POP_WR,
    S_CUR,
    S_FLUSH2
  } state_e;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_EDGE,
    MODE_PASS
  } mode_e;

  state_e              state_q;
  mode_e               mode_q;
  logic [TRIM_W-1:0]   trim_q;
  logic [TRIM_W-1:0]   t_q;
  logic [TRIM_W-1:0]   t_sat;
  logic [SAMPLE_W-1:0] smp_q;
  logic                cend_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [PTR_W-1:0]    rp_q;
  logic [ARC_W-1:0]    arc_q;
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_data_q;
  logic                out_last_q;
  logic [TUSER_W-1:0]  out_user_q;
  logic                out_free;
  logic                out_load;
  logic                pop_more;
  logic                ram_we;
  logic                ram_re;
  logic [PTR_W-1:0]    ram_waddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  // Effective trim length, capped at the store depth.
  assign t_sat = (trim_q > TRIM_LIMIT) ? TRIM_LIMIT : trim_q;

  assign out_free = !out_valid_q || m_axis_tready;
  assign pop_more = (cnt_q != '0) && (cnt_q >= CNT_W'(t_q));

  // The store is written only when the current sample is held and read only
  // while releasing, so one entry is never read and written in the same step.
  assign ram_we    = (state_q == S_CUR) && (mode_q == MODE_PASS) && (t_q != '0);
  assign ram_re    = (state_q == S_POP_RD) && pop_more;
  assign ram_waddr = PTR_W'(rp_q + cnt_q[PTR_W-1:0]);

  // A result is loaded into the output register in these cycles.
  assign out_load = out_free && (((state_q == S_FLUSH1) && (cnt_q != '0)) ||
                                 (state_q == S_POP_WR) ||
                                 ((state_q == S_CUR) && !ram_we) ||
                                 (state_q == S_FLUSH2));

  aet_ram #(
    .DEPTH(MAX_TRIM),
    .WIDTH(SAMPLE_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(smp_q),
    .re_i   (ram_re),
    .raddr_i(rp_q),
    .rdata_o(ram_rdata)
  );

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_q <= TRIM_RESET;
    end else if (cfg_we_i) begin
      trim_q <= cfg_wdata_i;
    end
  end

  // Sequencer with the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_ZERO;
      t_q         <= '0;
      smp_q       <= '0;
      cend_q      <= 1'b0;
      cnt_q       <= '0;
      rp_q        <= '0;
      arc_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
      out_user_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            smp_q  <= s_axis_tdata;
            cend_q <= s_axis_tlast;
            t_q    <= t_sat;
            if (s_axis_tdata == '0) begin
              mode_q  <= MODE_ZERO;
              state_q <= S_FLUSH1;
            end else if (arc_q < ARC_W'(t_sat)) begin
              mode_q  <= MODE_EDGE;
              state_q <= S_CUR;
            end else begin
              mode_q  <= MODE_PASS;
              state_q <= S_POP_RD;
            end
            // Arc position counts nonzero samples, saturates, and clears on a zero or a column end.
            if (s_axis_tdata == '0 || s_axis_tlast) begin
              arc_q <= '0;
            end else if (arc_q != ARC_SAT) begin
              arc_q <= arc_q + ARC_W'(1);
            end
          end
        end
        S_FLUSH1: begin
          // A gap releases every pending sample as a trimmed zero.
          if (cnt_q == '0) begin
            rp_q    <= '0;
            state_q <= S_CUR;
          end else if (out_free) begin
            out_data_q  <= '0;
            out_last_q  <= 1'b0;
            out_user_q  <= TUSER_W'(1) << TUSER_TRIMMED;
            cnt_q       <= cnt_q - CNT_W'(1);
          end
        end
        S_POP_RD: begin
          state_q <= pop_more ? S_POP_WR : S_CUR;
        end
        S_POP_WR: begin
          // Oldest pending sample leaves unchanged.
          if (out_free) begin
            out_data_q  <= ram_rdata;
            out_last_q  <= (t_q != '0) && !cend_q && (cnt_q == CNT_W'(t_q));
            out_user_q  <= '0;
            rp_q        <= rp_q + PTR_W'(1);
            cnt_q       <= cnt_q - CNT_W'(1);
            state_q     <= S_POP_RD;
          end
        end
        S_CUR: begin
          if (ram_we) begin
            // Current sample joins the pending store.
            cnt_q   <= cnt_q + CNT_W'(1);
            state_q <= cend_q ? S_FLUSH2 : S_IDLE;
          end else if (out_free) begin
            out_data_q  <= (mode_q == MODE_PASS) ? smp_q : '0;
            out_last_q  <= !(cend_q && cnt_q != '0);
            out_user_q  <= (TUSER_W'(mode_q == MODE_EDGE) << TUSER_TRIMMED) |
                           (TUSER_W'(cend_q && (cnt_q == '0)) << TUSER_DONE);
            if (cend_q && cnt_q != '0) begin
              state_q <= S_FLUSH2;
            end else begin
              if (cend_q) begin
                rp_q <= '0;
              end
              state_q <= S_IDLE;
            end
          end
        end
        S_FLUSH2: begin
          // Column end drains the store as trimmed zeros.
          if (out_free) begin
            out_data_q  <= '0;
            out_last_q  <= (cnt_q == CNT_W'(1));
            out_user_q  <= (TUSER_W'(1) << TUSER_TRIMMED) |
                           (TUSER_W'(cnt_q == CNT_W'(1)) << TUSER_DONE);
            cnt_q       <= cnt_q - CNT_W'(1);
            if (cnt_q == CNT_W'(1)) begin
              rp_q    <= '0;
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

  // The pending count never exceeds the store depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_TRIM))
    else $error("pending count above store depth");

  // A release is only issued while samples are pending.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP_WR |-> cnt_q != '0)
    else $error("release from an empty store");

  // The column-end drain runs only for a column end with pending samples.
  a_flush_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FLUSH2 |-> cend_q && cnt_q != '0)
    else $error("unexpected drain");

  // A column-done result is always the last result of its item.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[TUSER_DONE] |-> m_axis_tlast)
    else $error("column done without last result");

endmodule : arc_edge_trimmer
`default_nettype wire

// ===== verif/arc_edge_trimmer_tb.sv =====
// Testbench for the arc edge trimmer: directed and random sample columns checked against a predictor.
module arc_edge_trimmer_tb;
  import aet_pkg::*;

  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_ITEMS   = 140;

  // One output item as the block should produce it.
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                trimmed;
    logic                last;
    logic                done;
  } trim_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [TRIM_W-1:0]   cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [SAMPLE_W-1:0] s_axis_tdata;   // sample_in[31:0]
  logic                s_axis_tlast;   // column_end
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [SAMPLE_W-1:0] m_axis_tdata;   // sample_out[31:0]
  logic                m_axis_tlast;   // last_result
  logic [TUSER_W-1:0]  m_axis_tuser;   // trimmed, column_done

  // Predictor state: trim setting, samples still waiting, and the open arc length.
  logic [TRIM_W-1:0]   trim_reg;
  logic [SAMPLE_W-1:0] waiting_samples[$];
  int                  arc_pos;
  trim_result_t        step_results[$];
  trim_result_t        expected_q[$];

  int items_sent;
  int columns_sent;
  int results_seen;
  int mismatches;
  int quiet_cycles;
  bit src_jitter;
  bit sink_jitter;
  bit hold_req;

  arc_edge_trimmer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Gap lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int effective_trim();
    return (trim_reg > TRIM_LIMIT) ? MAX_TRIM : int'(trim_reg);
  endfunction

  function automatic void emit_result(logic [SAMPLE_W-1:0] v, logic trm);
    step_results.push_back(trim_result_t'{v, trm, 1'b0, 1'b0});
  endfunction

  // Arc end: everything still waiting comes out as trimmed zeros.
  function automatic void flush_waiting();
    while (waiting_samples.size() > 0) begin
      void'(waiting_samples.pop_front());
      emit_result('0, 1'b1);
    end
    arc_pos = 0;
  endfunction

  // Work out the output items caused by one accepted sample.
  function automatic void predict_trim(logic [SAMPLE_W-1:0] d, logic col_end);
    int           t;
    trim_result_t tail;
    t = effective_trim();
    step_results.delete();
    if (d == '0) begin
      flush_waiting();
      emit_result('0, 1'b0);
    end else begin
      if (arc_pos < t) begin
        emit_result('0, 1'b1);
      end else begin
        // A lowered trim releases older samples before this one is held.
        while (waiting_samples.size() > 0 && waiting_samples.size() >= t)
          emit_result(waiting_samples.pop_front(), 1'b0);
        if (t > 0) waiting_samples.push_back(d);
        else emit_result(d, 1'b0);
      end
      if (arc_pos < 63) arc_pos++;
    end
    if (col_end) flush_waiting();
    // A sample that only joins the waiting samples causes no item at all.
    if (step_results.size() > 0) begin
      tail = step_results.pop_back();
      tail.last = 1'b1;
      tail.done = col_end;
      step_results.push_back(tail);
    end
    foreach (step_results[i]) expected_q.push_back(step_results[i]);
  endfunction

  // Offer one sample, wait for the handshake, then update the prediction.
  task automatic send_sample(logic [SAMPLE_W-1:0] d, logic col_end);
    int gap;
    gap = src_jitter ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= col_end;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_trim(d, col_end);
    items_sent++;
    if (col_end) columns_sent++;
  endtask

  // Stop sending until every predicted item has come out, then let the block settle.
  task automatic wait_for_quiet();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_trim(logic [TRIM_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    trim_reg = v;
  endtask

  function automatic logic [SAMPLE_W-1:0] random_nonzero();
    logic [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = $urandom_range(0, 1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
      3: v = $urandom_range(0, 1) ? $urandom_range(1, 255) : -$urandom_range(1, 255);
      default: v = $urandom;
    endcase
    return (v == '0) ? 32'h0001_0000 : v;
  endfunction

  function automatic logic [TRIM_W-1:0] pick_trim();
    case ($urandom_range(0, 9))
      0: return TRIM_W'(0);
      1: return TRIM_W'(1);
      2: return TRIM_W'(2);
      3: return TRIM_W'(32);
      4: return TRIM_W'(63);
      5: return TRIM_W'(33);
      6: return TRIM_W'($urandom_range(3, 12));
      7: return TRIM_W'($urandom_range(0, 63));
      default: return TRIM_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic int pick_arc_len(int t);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(1, 3);
    if (r < 85) return $urandom_range(1, 2 * t + 8);
    return $urandom_range(60, 75);
  endfunction

  // Extreme values of the sample at the reset trim, closed by a zero.
  task automatic test_extremes();
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h0000_0001, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    wait_for_quiet();
  endtask

  // Column end on a nonzero sample flushes the pending samples.
  task automatic test_column_end();
    write_trim(TRIM_W'(1));
    send_sample(32'd5, 1'b0);
    send_sample(32'd6, 1'b0);
    send_sample(32'd7, 1'b0);
    send_sample(32'd8, 1'b1);
    wait_for_quiet();
  endtask

  // With no trimming every sample passes straight through.
  task automatic test_trim_zero();
    write_trim(TRIM_W'(0));
    send_sample(32'd3, 1'b0);
    send_sample(32'd0, 1'b0);
    send_sample(32'd9, 1'b1);
    wait_for_quiet();
  endtask

  // Trim settings above the store depth act as the depth; column end on a zero.
  task automatic test_trim_above_limit();
    write_trim(TRIM_W'(63));
    send_sample(32'hA5A5_A5A5, 1'b0);
    send_sample(32'h5A5A_5A5A, 1'b0);
    send_sample(32'd0, 1'b1);
    wait_for_quiet();
  endtask

  // Lowering the trim inside an open arc releases the older pending samples.
  task automatic test_trim_lowered();
    write_trim(TRIM_W'(4));
    for (int i = 0; i < 7; i++) send_sample(32'h0001_0000 + i, 1'b0);
    wait_for_quiet();
    write_trim(TRIM_W'(1));
    send_sample(32'h0002_0000, 1'b0);
    send_sample(32'd0, 1'b1);
    wait_for_quiet();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_stalled_output();
    write_trim(TRIM_W'(32));
    src_jitter = 1'b0;
    hold_req   = 1'b1;
    for (int i = 0; i < 44; i++) send_sample(random_nonzero(), 1'b0);
    send_sample(random_nonzero(), 1'b1);
    wait_for_quiet();
  endtask

  // Random columns of arcs under changing trim settings and idling.
  task automatic test_random_columns();
    int                  target;
    int                  col_len;
    int                  arc_left;
    logic [SAMPLE_W-1:0] d;
    logic                col_last;
    target   = items_sent + RANDOM_ITEMS;
    arc_left = 0;
    while (items_sent < target) begin
      // The sender pauses here until every expected item has arrived.
      wait_for_quiet();
      write_trim(pick_trim());
      src_jitter  = ($urandom_range(0, 3) != 0);
      sink_jitter = ($urandom_range(0, 3) != 0);
      col_len = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(15, 50);
      for (int i = 0; i < col_len; i++) begin
        if (arc_left == 0) begin
          d = '0;
          arc_left = pick_arc_len(effective_trim());
        end else begin
          d = random_nonzero();
          arc_left--;
        end
        // Most columns close at the end; some stay open across a trim change.
        col_last = (i == col_len - 1) ? ($urandom_range(0, 3) != 0)
                                      : ($urandom_range(0, 39) == 0);
        send_sample(d, col_last);
      end
    end
    wait_for_quiet();
  endtask

  function automatic void check_field(string name, logic [SAMPLE_W-1:0] exp_v,
                                      logic [SAMPLE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 50)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endfunction

  // Result checker: each output item against the oldest prediction.
  always @(posedge clk_i) begin
    trim_result_t got;
    trim_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = trim_result_t'{m_axis_tdata, m_axis_tuser[TUSER_TRIMMED], m_axis_tlast,
                           m_axis_tuser[TUSER_DONE]};
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 50)
          $display("%0t: unexpected item, expected none, actual %h", $time, got);
      end else begin
        want = expected_q.pop_front();
        check_field("sample_out", want.value, got.value);
        check_field("trimmed", SAMPLE_W'(want.trimmed), SAMPLE_W'(got.trimmed));
        check_field("last_result", SAMPLE_W'(want.last), SAMPLE_W'(got.last));
        check_field("column_done", SAMPLE_W'(want.done), SAMPLE_W'(got.done));
      end
    end
  end

  // Receiver: random stalls, or one long hold when a test asks for it.
  initial begin
    int n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (sink_jitter && $urandom_range(0, 3) == 0) begin
        n = pick_gap();
        if (n == 0) n = 1;
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: too long with no item moving on either side ends the run.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d items still expected", $time,
               WATCHDOG_LIMIT, expected_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    trim_reg      = TRIM_RESET;
    arc_pos       = 0;
    items_sent    = 0;
    columns_sent  = 0;
    results_seen  = 0;
    mismatches    = 0;
    quiet_cycles  = 0;
    src_jitter    = 1'b1;
    sink_jitter   = 1'b1;
    hold_req      = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_column_end();
    test_trim_zero();
    test_trim_above_limit();
    test_trim_lowered();
    test_stalled_output();
    test_random_columns();

    if (expected_q.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected items never arrived", $time, expected_q.size());
    end
    $display("Sent %0d samples in %0d closed columns and checked %0d output items.",
             items_sent, columns_sent, results_seen);
    $display("Trim settings from 0 to 63, arcs across trim changes, long output hold.");
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
src/aet_pkg.sv
src/aet_ram.sv
src/arc_edge_trimmer.sv
verif/arc_edge_trimmer_tb.sv
